@@ src/ddo_pkg.sv @@
// Shared types and constants for the differential-drive odometry core.
`default_nettype none
package ddo_pkg;

    typedef struct packed {
        logic [15:0]        start_word;
        logic signed [15:0] rpm_left;
        logic signed [15:0] rpm_right;
        logic [15:0]        battery_centivolts;
        logic [15:0]        board_temperature;
        logic [15:0]        current_left;
        logic [15:0]        current_right;
        logic [15:0]        frame_checksum;
        logic [19:0]        elapsed_us;
    } in_t;

    typedef struct packed {
        logic               frame_valid;
        logic               low_battery;
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
        logic signed [47:0] position_x;
        logic signed [47:0] position_y;
        logic [31:0]        heading;
    } out_t;

    localparam int MUL_AW = 56;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    localparam logic [2:0] REG_START_MARKER = 3'd0;
    localparam logic [2:0] REG_LINEAR_SCALE = 3'd1;
    localparam logic [2:0] REG_ANGULAR_SCALE = 3'd2;
    localparam logic [2:0] REG_LOW_VOLTAGE = 3'd3;
    localparam logic [2:0] REG_WARN_INTERVAL = 3'd4;

    localparam logic [31:0] HEAD_K = 32'd44798134;
    localparam logic [31:0] DIST_K = 32'd1099512;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

endpackage
`default_nettype wire

@@ src/diff_drive_feedback_odometry_core.sv @@
// Top level of the differential-drive odometry core: frame check, sequencer and pose state.
//
// Channel   Signals                          Direction
// config    cfg_write, cfg_index, cfg_data   in
// frame     in_valid, in_ready, in_data      in
// result    out_valid, out_ready, out_data   out
//
// A valid frame makes eight passes through the shared bit-serial 56 by 32 multiplier;
// an invalid frame skips the multiplier and goes straight to the result register.
// The CORDIC runs alongside the first multiplies; the position steps wait for its result.
// One request is in flight at a time; the next is taken once the result is registered.
// A stalled result holds in its output register while the next request is taken.
// Reset clears the pose, the time counters and the configuration to its defaults.
`default_nettype none
module diff_drive_feedback_odometry_core #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ddo_pkg::in_t   in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ddo_pkg::out_t       out_data
);
    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_t;

    localparam int PW = ddo_pkg::MUL_PW;
    localparam int AW = ddo_pkg::MUL_AW;

    state_t state_reg;
    logic [2:0]  step_reg;

    logic [15:0] start_marker_reg, low_voltage_reg;
    logic [31:0] linear_scale_reg, angular_scale_reg;
    logic [23:0] warn_interval_reg;

    logic signed [47:0] pose_x_reg, pose_y_reg;
    logic [31:0] pose_heading_reg;
    logic [23:0] tsv_reg, tsw_reg, dt_reg;

    logic        valid_reg, warn_reg;
    logic        d_neg_reg, s_neg_reg;
    logic [16:0] d_mag_reg, s_mag_reg;
    logic signed [31:0] lin_reg, ang_reg;
    logic [55:0] m_reg;
    logic [44:0] q_reg;
    logic        trig_ok_reg;
    logic signed [31:0] cos_reg, sin_reg;

    logic        out_valid_reg;
    ddo_pkg::out_t out_reg;

    logic        accept;
    logic [15:0] xsum;
    logic        frame_ok;
    logic [24:0] tsv_sum, tsw_sum;
    logic [23:0] tsv_sat, tsw_sat;
    logic        warn;
    logic signed [16:0] d_val, s_sum;

    ddo_pkg::mul_req_t mul_req;
    logic              mul_done;
    logic [PW-1:0]     prod;

    logic              cordic_start, cordic_done;
    logic signed [31:0] cos_w, sin_w;

    logic signed [50:0] vel_p, vel_s;
    logic signed [34:0] vel_sh;
    logic signed [31:0] vel_sat;
    logic        vel_neg;
    logic [31:0] lin_mag, ang_mag;
    logic        trig_neg;
    logic [47:0] dpos;
    logic [31:0] dh;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign xsum = in_data.start_word ^ in_data.rpm_left ^ in_data.rpm_right
                ^ in_data.battery_centivolts ^ in_data.board_temperature
                ^ in_data.current_left ^ in_data.current_right;
    assign frame_ok = (in_data.start_word == start_marker_reg)
                   && (xsum == in_data.frame_checksum);
    assign tsv_sum = {1'b0, tsv_reg} + {5'd0, in_data.elapsed_us};
    assign tsw_sum = {1'b0, tsw_reg} + {5'd0, in_data.elapsed_us};
    assign tsv_sat = tsv_sum[24] ? 24'hFFFFFF : tsv_sum[23:0];
    assign tsw_sat = tsw_sum[24] ? 24'hFFFFFF : tsw_sum[23:0];
    assign warn = (tsw_sat > warn_interval_reg)
               && (in_data.battery_centivolts < low_voltage_reg);
    assign d_val = 17'(in_data.rpm_left) - 17'(in_data.rpm_right);
    assign s_sum = 17'(in_data.rpm_left) + 17'(in_data.rpm_right);

    assign cordic_start = accept && frame_ok;

    ddo_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (pose_heading_reg),
        .done    (cordic_done),
        .cos_out (cos_w),
        .sin_out (sin_w)
    );

    assign lin_mag = lin_reg[31] ? 32'(-lin_reg) : 32'(lin_reg);
    assign ang_mag = ang_reg[31] ? 32'(-ang_reg) : 32'(ang_reg);

    always_comb
    begin
        mul_req.start = (state_reg == S_ISSUE) && (step_reg < 3'd4 || trig_ok_reg);
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (step_reg)
            3'd0:
            begin
                mul_req.a = AW'(d_mag_reg);
                mul_req.b = linear_scale_reg;
            end
            3'd1:
            begin
                mul_req.a = AW'(s_mag_reg);
                mul_req.b = angular_scale_reg;
            end
            3'd2:
            begin
                mul_req.a = AW'(lin_mag);
                mul_req.b = {8'd0, dt_reg};
            end
            3'd3:
            begin
                mul_req.a = m_reg;
                mul_req.b = ddo_pkg::DIST_K;
            end
            3'd4:
            begin
                mul_req.a = AW'(q_reg);
                mul_req.b = cos_reg[31] ? 32'(-cos_reg) : 32'(cos_reg);
            end
            3'd5:
            begin
                mul_req.a = AW'(q_reg);
                mul_req.b = sin_reg[31] ? 32'(-sin_reg) : 32'(sin_reg);
            end
            3'd6:
            begin
                mul_req.a = AW'(ang_mag);
                mul_req.b = {8'd0, dt_reg};
            end
            3'd7:
            begin
                mul_req.a = m_reg;
                mul_req.b = ddo_pkg::HEAD_K;
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (prod)
    );

    always_comb
    begin
        vel_neg  = (step_reg == 3'd0) ? d_neg_reg : s_neg_reg;
        vel_p    = {1'b0, prod[49:0]};
        vel_s    = vel_neg ? -vel_p : vel_p;
        vel_sh   = 35'(vel_s >>> 16);
        if (vel_sh > 35'sd2147483647)
            vel_sat = 32'sh7FFFFFFF;
        else if (vel_sh < -35'sd2147483648)
            vel_sat = 32'sh80000000;
        else
            vel_sat = 32'(vel_sh);
        trig_neg = lin_reg[31] ^ ((step_reg == 3'd4) ? cos_reg[31] : sin_reg[31]);
        dpos     = trig_neg ? -prod[77:30] : prod[77:30];
        dh       = ang_reg[31] ? -prod[63:32] : prod[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            step_reg          <= '0;
            start_marker_reg  <= 16'hABCD;
            linear_scale_reg  <= 32'd17895697;
            angular_scale_reg <= 32'd89478485;
            low_voltage_reg   <= 16'd3500;
            warn_interval_reg <= 24'd1000000;
            pose_x_reg        <= '0;
            pose_y_reg        <= '0;
            pose_heading_reg  <= '0;
            tsv_reg           <= '0;
            tsw_reg           <= '0;
            trig_ok_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ddo_pkg::REG_START_MARKER:  start_marker_reg  <= cfg_data[15:0];
                    ddo_pkg::REG_LINEAR_SCALE:  linear_scale_reg  <= cfg_data;
                    ddo_pkg::REG_ANGULAR_SCALE: angular_scale_reg <= cfg_data;
                    ddo_pkg::REG_LOW_VOLTAGE:   low_voltage_reg   <= cfg_data[15:0];
                    ddo_pkg::REG_WARN_INTERVAL: warn_interval_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            if (cordic_done)
                trig_ok_reg <= 1'b1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        trig_ok_reg <= 1'b0;
                        step_reg    <= '0;
                        if (frame_ok)
                        begin
                            tsv_reg   <= '0;
                            tsw_reg   <= warn ? 24'd0 : tsw_sat;
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            tsv_reg   <= tsv_sat;
                            tsw_reg   <= tsw_sat;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_ISSUE:
                begin
                    if (mul_req.start)
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (step_reg)
                            3'd4: pose_x_reg <= pose_x_reg + $signed(dpos);
                            3'd5: pose_y_reg <= pose_y_reg + $signed(dpos);
                            3'd7: pose_heading_reg <= pose_heading_reg + dh;
                            default: ;
                        endcase
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= (step_reg == 3'd7) ? S_DONE : S_ISSUE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            valid_reg <= frame_ok;
            warn_reg  <= frame_ok && warn;
            dt_reg    <= tsv_sat;
            d_neg_reg <= d_val[16];
            d_mag_reg <= d_val[16] ? 17'(-d_val) : 17'(d_val);
            s_neg_reg <= !s_sum[16] && (s_sum != 17'sd0);
            s_mag_reg <= s_sum[16] ? 17'(-s_sum) : 17'(s_sum);
            lin_reg   <= '0;
            ang_reg   <= '0;
        end
        if (cordic_done)
        begin
            cos_reg <= cos_w;
            sin_reg <= sin_w;
        end
        if (state_reg == S_WAIT && mul_done)
        begin
            unique case (step_reg)
                3'd0: lin_reg <= vel_sat;
                3'd1: ang_reg <= vel_sat;
                3'd2: m_reg <= prod[55:0];
                3'd3: q_reg <= prod[76:32];
                3'd6: m_reg <= prod[55:0];
                default: ;
            endcase
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_reg.frame_valid      <= valid_reg;
            out_reg.low_battery      <= warn_reg;
            out_reg.linear_velocity  <= lin_reg;
            out_reg.angular_velocity <= ang_reg;
            out_reg.position_x       <= pose_x_reg;
            out_reg.position_y       <= pose_y_reg;
            out_reg.heading          <= pose_heading_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a previous one was still in work");
    a_warn_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.frame_valid || !out_data.low_battery))
        else $error("low battery warning on an invalid frame");
    a_invalid_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.frame_valid)
            |-> (out_data.linear_velocity == 32'sd0 && out_data.angular_velocity == 32'sd0))
        else $error("nonzero speed reported for an invalid frame");
    a_trig_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && step_reg == 3'd3 && mul_done) |-> (trig_ok_reg || cordic_done))
        else $error("cosine and sine not ready when the position update begins");
`endif
endmodule
`default_nettype wire

@@ src/ddo_mul.sv @@
// Shift-and-add unsigned multiplier that retires one multiplier bit per cycle.
`default_nettype none
module ddo_mul (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ddo_pkg::mul_req_t       req,
    output logic                         done,
    output logic [ddo_pkg::MUL_PW-1:0]   product
);
    localparam int AW = ddo_pkg::MUL_AW;
    localparam int BW = ddo_pkg::MUL_BW;
    localparam int CW = $clog2(BW);

    logic [AW-1:0] a_reg;
    logic [AW-1:0] hi_reg;
    logic [BW-1:0] lo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [AW:0]   sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[AW:1];
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};
endmodule
`default_nettype wire

@@ src/ddo_cordic.sv @@
// Iterative CORDIC that returns clamped Q2.30 cosine and sine of a binary angle.
`default_nettype none
module ddo_cordic #(
    parameter int ITERATIONS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        angle,
    output logic                    done,
    output logic signed [31:0]      cos_out,
    output logic signed [31:0]      sin_out
);
    localparam int CW = $clog2(ITERATIONS + 1);
    localparam logic signed [33:0] ONE_Q30_C = ddo_pkg::ONE_Q30;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [31:0] cos_reg, sin_reg;

    logic signed [33:0] z_init, z_fold, xs, ys, at, xf, yf, xc, yc;
    logic               fold;
    logic [4:0]         idx;

    always_comb
    begin
        z_init = {{2{angle[31]}}, angle};
        fold   = 1'b0;
        z_fold = z_init;
        if (z_init > ONE_Q30_C)
        begin
            z_fold = z_init - (ONE_Q30_C <<< 1);
            fold   = 1'b1;
        end
        else if (z_init < -ONE_Q30_C)
        begin
            z_fold = z_init + (ONE_Q30_C <<< 1);
            fold   = 1'b1;
        end
        idx = 5'(cnt_reg);
        xs  = x_reg >>> idx;
        ys  = y_reg >>> idx;
        at  = {2'b00, ddo_pkg::ATAN_BAM[idx]};
        xf  = flip_reg ? -x_reg : x_reg;
        yf  = flip_reg ? -y_reg : y_reg;
        xc  = (xf > ONE_Q30_C) ? ONE_Q30_C : ((xf < -ONE_Q30_C) ? -ONE_Q30_C : xf);
        yc  = (yf > ONE_Q30_C) ? ONE_Q30_C : ((yf < -ONE_Q30_C) ? -ONE_Q30_C : yf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(ITERATIONS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= ddo_pkg::CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= fold;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(ITERATIONS))
            begin
                cos_reg <= 32'(xc);
                sin_reg <= 32'(yc);
            end
            else if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
endmodule
`default_nettype wire

@@ bench/tb_diff_drive_feedback_odometry_core.sv @@
// Testbench for the differential-drive odometry core with its own pose predictor.
`timescale 1ns / 100ps
`default_nettype none

class odometry_scoreboard;
    logic [15:0] start_marker;
    logic [31:0] linear_scale;
    logic [31:0] angular_scale;
    logic [15:0] low_voltage_threshold;
    logic [23:0] warning_interval_us;
    logic [47:0] pose_x;
    logic [47:0] pose_y;
    logic [31:0] pose_heading;
    logic [23:0] time_since_valid;
    logic [23:0] time_since_warning;
    ddo_pkg::out_t pending_results[$];
    int errors;

    function new();
        start_marker = 16'hABCD;
        linear_scale = 32'd17895697;
        angular_scale = 32'd89478485;
        low_voltage_threshold = 16'd3500;
        warning_interval_us = 24'd1000000;
        pose_x = '0;
        pose_y = '0;
        pose_heading = '0;
        time_since_valid = '0;
        time_since_warning = '0;
        errors = 0;
    endfunction

    function void write_register(logic [2:0] index, logic [31:0] value);
        case (index)
            ddo_pkg::REG_START_MARKER: start_marker = value[15:0];
            ddo_pkg::REG_LINEAR_SCALE: linear_scale = value;
            ddo_pkg::REG_ANGULAR_SCALE: angular_scale = value;
            ddo_pkg::REG_LOW_VOLTAGE: low_voltage_threshold = value[15:0];
            ddo_pkg::REG_WARN_INTERVAL: warning_interval_us = value[23:0];
            default: ;
        endcase
    endfunction

    static function logic [23:0] add_saturate(logic [23:0] a, logic [19:0] b);
        logic [24:0] r;
        r = {1'b0, a} + b;
        return r[24] ? 24'hFFFFFF : r[23:0];
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint scale_truncate(longint a, longint c, int s);
        logic [127:0] m;
        logic [127:0] k;
        logic [127:0] p;
        logic neg;
        neg = (a < 0) != (c < 0);
        m = (a < 0) ? -a : a;
        k = (c < 0) ? -c : c;
        p = (m * k) >> s;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    static function void rotate(logic [31:0] angle, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit flip;
        z = longint'(signed'(angle));
        flip = 0;
        x = 652032874;
        y = 0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1;
        end
        else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> (i % 32);
            ys = y >>> (i % 32);
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= longint'(ddo_pkg::ATAN_BAM[i % 32]);
            end
            else begin
                x += ys;
                y -= xs;
                z += longint'(ddo_pkg::ATAN_BAM[i % 32]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        if (x > 64'sd1073741824) x = 64'sd1073741824;
        if (x < -64'sd1073741824) x = -64'sd1073741824;
        if (y > 64'sd1073741824) y = 64'sd1073741824;
        if (y < -64'sd1073741824) y = -64'sd1073741824;
        c = x;
        s = y;
    endfunction

    function void note_request(ddo_pkg::in_t d);
        ddo_pkg::out_t r;
        logic [15:0] xsum;
        bit valid;
        longint rl;
        longint rr;
        longint lin;
        longint ang;
        longint dt;
        longint c;
        longint s;
        longint q;
        longint dh;
        xsum = d.start_word ^ d.rpm_left ^ d.rpm_right ^ d.battery_centivolts
            ^ d.board_temperature ^ d.current_left ^ d.current_right;
        valid = (d.start_word == start_marker) && (xsum == d.frame_checksum);
        r = '0;
        time_since_valid = add_saturate(time_since_valid, d.elapsed_us);
        time_since_warning = add_saturate(time_since_warning, d.elapsed_us);
        if (valid) begin
            rl = longint'(d.rpm_left);
            rr = longint'(d.rpm_right);
            dt = longint'(time_since_valid);
            lin = clamp32(((rl - rr) * longint'(linear_scale)) >>> 16);
            ang = clamp32((-(rl + rr) * longint'(angular_scale)) >>> 16);
            if (time_since_warning > warning_interval_us
                && d.battery_centivolts < low_voltage_threshold) begin
                r.low_battery = 1'b1;
                time_since_warning = '0;
            end
            rotate(pose_heading, c, s);
            q = scale_truncate(lin * dt, 1099512, 32);
            pose_x = pose_x + 48'(scale_truncate(q, c, 30));
            pose_y = pose_y + 48'(scale_truncate(q, s, 30));
            dh = scale_truncate(ang * dt, 44798134, 32);
            pose_heading = pose_heading + 32'(dh);
            time_since_valid = '0;
            r.frame_valid = 1'b1;
            r.linear_velocity = 32'(lin);
            r.angular_velocity = 32'(ang);
        end
        r.position_x = pose_x;
        r.position_y = pose_y;
        r.heading = pose_heading;
        pending_results.push_back(r);
    endfunction

    function void check_result(ddo_pkg::out_t a);
        ddo_pkg::out_t e;
        if (pending_results.size() == 0) begin
            $error("unexpected result %p", a);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (a.frame_valid !== e.frame_valid) begin
            $error("frame_valid exp %0d got %0d", e.frame_valid, a.frame_valid);
            errors++;
        end
        if (a.low_battery !== e.low_battery) begin
            $error("low_battery exp %0d got %0d", e.low_battery, a.low_battery);
            errors++;
        end
        if (a.linear_velocity !== e.linear_velocity) begin
            $error("linear_velocity exp %0d got %0d", e.linear_velocity, a.linear_velocity);
            errors++;
        end
        if (a.angular_velocity !== e.angular_velocity) begin
            $error("angular_velocity exp %0d got %0d", e.angular_velocity, a.angular_velocity);
            errors++;
        end
        if (a.position_x !== e.position_x) begin
            $error("position_x exp %0d got %0d", e.position_x, a.position_x);
            errors++;
        end
        if (a.position_y !== e.position_y) begin
            $error("position_y exp %0d got %0d", e.position_y, a.position_y);
            errors++;
        end
        if (a.heading !== e.heading) begin
            $error("heading exp %0d got %0d", e.heading, a.heading);
            errors++;
        end
    endfunction
endclass

module tb_diff_drive_feedback_odometry_core;
    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    ddo_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    ddo_pkg::out_t out_data;
    bit calm = 0;
    bit done = 0;
    int cycle_count = 0;
    odometry_scoreboard pose_book;

    diff_drive_feedback_odometry_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) pose_book.check_result(out_data);
    end

    initial
    begin
        int hold;
        forever begin
            @(posedge clk);
            if (calm || $urandom_range(0, 5) != 0) begin
                out_ready <= 1;
            end
            else begin
                hold = $urandom_range(1, 19);
                out_ready <= 0;
                repeat (hold) @(posedge clk);
                out_ready <= 1;
            end
        end
    end

    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 0;
        pose_book.write_register(index, value);
    endtask

    task automatic send_request(ddo_pkg::in_t d);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= d;
        do @(posedge clk); while (!in_ready);
        pose_book.note_request(d);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pose_book.pending_results.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic ddo_pkg::in_t make_frame(bit good, logic [15:0] marker);
        ddo_pkg::in_t d;
        d = ddo_pkg::in_t'($bits(ddo_pkg::in_t)'({$urandom, $urandom, $urandom,
            $urandom, $urandom}));
        if ($urandom_range(0, 3) == 0) d.rpm_left = 16'($urandom_range(0, 1) ? 32767 : 32768);
        if ($urandom_range(0, 3) == 0) d.rpm_right = 16'($urandom_range(0, 1) ? 32767 : 32768);
        if ($urandom_range(0, 2) != 0) d.rpm_left = 16'($signed($urandom_range(0, 600)) - 300);
        if ($urandom_range(0, 2) != 0) d.rpm_right = 16'($signed($urandom_range(0, 600)) - 300);
        case ($urandom_range(0, 3))
            0: d.elapsed_us = 20'($urandom_range(0, 20000));
            1: d.elapsed_us = 20'hFFFFF;
            default: d.elapsed_us = 20'($urandom_range(5000, 15000));
        endcase
        d.battery_centivolts = $urandom_range(0, 1) ? 16'($urandom_range(3000, 4000)) : d.battery_centivolts;
        if (good) begin
            d.start_word = marker;
            d.frame_checksum = d.start_word ^ d.rpm_left ^ d.rpm_right
                ^ d.battery_centivolts ^ d.board_temperature ^ d.current_left
                ^ d.current_right;
        end
        else if ($urandom_range(0, 1)) begin
            d.start_word = marker;
        end
        return d;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_request(make_frame($urandom_range(0, 9) < 8, pose_book.start_marker));
    endtask

    initial
    begin
        ddo_pkg::in_t d;
        pose_book = new();
        repeat (6) @(posedge clk);
        rst_n <= 1;

        d = make_frame(1, 16'hABCD);
        d.rpm_left = 16'sh7FFF;
        d.rpm_right = -16'sh8000;
        d.elapsed_us = 20'hFFFFF;
        d.battery_centivolts = 16'd0;
        d.frame_checksum = d.start_word ^ d.rpm_left ^ d.rpm_right ^ d.battery_centivolts
            ^ d.board_temperature ^ d.current_left ^ d.current_right;
        send_request(d);
        d.rpm_left = -16'sh8000;
        d.rpm_right = -16'sh8000;
        d.frame_checksum = d.start_word ^ d.rpm_left ^ d.rpm_right ^ d.battery_centivolts
            ^ d.board_temperature ^ d.current_left ^ d.current_right;
        send_request(d);
        d.frame_checksum = ~d.frame_checksum;
        send_request(d);
        d = make_frame(0, 16'h1234);
        send_request(d);
        for (int i = 0; i < 16; i++) send_request(make_frame(1, 16'hABCD));
        wait_drained();

        write_register(ddo_pkg::REG_START_MARKER, 32'hFFFF0000);
        write_register(ddo_pkg::REG_LINEAR_SCALE, 32'hFFFFFFFF);
        write_register(ddo_pkg::REG_ANGULAR_SCALE, 32'hFFFFFFFF);
        write_register(ddo_pkg::REG_LOW_VOLTAGE, 32'h0000FFFF);
        write_register(ddo_pkg::REG_WARN_INTERVAL, 32'd0);
        run_random(400);
        wait_drained();

        write_register(ddo_pkg::REG_START_MARKER, 32'd0);
        write_register(ddo_pkg::REG_LINEAR_SCALE, 32'd0);
        write_register(ddo_pkg::REG_ANGULAR_SCALE, 32'd0);
        write_register(ddo_pkg::REG_LOW_VOLTAGE, 32'd0);
        write_register(ddo_pkg::REG_WARN_INTERVAL, 32'hFFFFFF);
        write_register(3'd7, $urandom);
        run_random(300);
        wait_drained();

        write_register(ddo_pkg::REG_START_MARKER, $urandom);
        write_register(ddo_pkg::REG_LINEAR_SCALE, $urandom);
        write_register(ddo_pkg::REG_ANGULAR_SCALE, $urandom);
        write_register(ddo_pkg::REG_LOW_VOLTAGE, 32'd3500);
        write_register(ddo_pkg::REG_WARN_INTERVAL, 32'($urandom_range(0, 50000)));
        run_random(500);
        wait_drained();

        write_register(ddo_pkg::REG_LINEAR_SCALE, 32'd17895697);
        write_register(ddo_pkg::REG_ANGULAR_SCALE, 32'd89478485);
        calm = 1;
        run_random(530);
        wait_drained();

        if (pose_book.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
src/ddo_pkg.sv
src/ddo_mul.sv
src/ddo_cordic.sv
src/diff_drive_feedback_odometry_core.sv
bench/tb_diff_drive_feedback_odometry_core.sv
